[sv/assert_macros.svh]
// Assertion helpers shared by the alert delay qualifier RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ADQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("adq assertion failed");

// Condition that must never be true outside reset.
`define ADQ_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("adq forbidden condition seen");

`endif

[sv/adq_pkg.sv]
// Package for the alert delay qualifier: field widths, codes and word types.
// No dependencies; used by the interfaces, the core and the top level.
`timescale 1ns / 1ps
`default_nettype none
package adq_pkg;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned ALERT_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Item actions.
  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_DISARM = 2'd2
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALERT_NUMBER  = 2'd0,
    CFG_RAISE_DELAY   = 2'd1,
    CFG_SILENCE_DELAY = 2'd2
  } cfg_reg_e;

  // One input word as held in the input register.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                condition;
  } item_t;

  // Outcome of one processed word.
  typedef struct packed {
    logic emit;
    logic raised;
  } result_t;

endpackage
`default_nettype wire

[sv/adq_item_if.sv]
// Input channel of the alert delay qualifier: valid/ready plus one item.
// Depends on adq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface adq_item_if
  import adq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic                condition;

  modport source (output valid, action, condition, input ready);
  modport sink   (input valid, action, condition, output ready);
endinterface
`default_nettype wire

[sv/adq_result_if.sv]
// Result channel of the alert delay qualifier: valid/ready plus a notification.
// Depends on adq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface adq_result_if
  import adq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ALERT_W-1:0] notified_alert;
  logic               raised;

  modport source (output valid, notified_alert, raised, input ready);
  modport sink   (input valid, notified_alert, raised, output ready);
endinterface
`default_nettype wire

[sv/adq_cfg_if.sv]
// Configuration write channel: valid/ready, register index and write data.
// Depends on adq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface adq_cfg_if
  import adq_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/adq_core.sv]
// Alert state and delay counter of the qualifier, updated once per word.
// Depends on adq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module adq_core
  import adq_pkg::*;
#(
  parameter int unsigned DELAY_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire item_t                  item_i,
  input  wire logic [DELAY_WIDTH-1:0] raise_delay_i,
  input  wire logic [DELAY_WIDTH-1:0] silence_delay_i,
  output result_t                     result_o
);

  localparam logic [DELAY_WIDTH-1:0] DelayOne = DELAY_WIDTH'(1);

  logic                   alert_up_q, alert_up_d;
  logic                   raise_q, raise_d;
  logic                   silence_q, silence_d;
  logic [DELAY_WIDTH-1:0] ticks_q, ticks_d;
  logic [DELAY_WIDTH-1:0] ticks_dec;
  logic [DELAY_WIDTH-1:0] start_delay;
  action_e                action;

  assign action      = action_e'(item_i.action);
  assign ticks_dec   = ticks_q - DelayOne;
  assign start_delay = item_i.condition ? raise_delay_i : silence_delay_i;

  // Next state and notification for the word in the input register.
  always_comb begin
    alert_up_d      = alert_up_q;
    raise_d         = raise_q;
    silence_d       = silence_q;
    ticks_d         = ticks_q;
    result_o.emit   = 1'b0;
    result_o.raised = 1'b0;
    unique case (action)
      ACT_SAMPLE: begin
        if (item_i.condition == alert_up_q) begin
          // Sample agrees with the state: drop the delay that would change it.
          if (alert_up_q) begin
            silence_d = 1'b0;
          end else begin
            raise_d = 1'b0;
          end
          if (!raise_d && !silence_d) begin
            ticks_d = '0;
          end
        end else if (start_delay == '0) begin
          // Zero delay switches the state at once.
          raise_d         = 1'b0;
          silence_d       = 1'b0;
          ticks_d         = '0;
          alert_up_d      = item_i.condition;
          result_o.emit   = 1'b1;
          result_o.raised = item_i.condition;
        end else if (item_i.condition) begin
          if (!raise_q) begin
            raise_d   = 1'b1;
            silence_d = 1'b0;
            ticks_d   = start_delay;
          end
        end else begin
          if (!silence_q) begin
            silence_d = 1'b1;
            raise_d   = 1'b0;
            ticks_d   = start_delay;
          end
        end
      end
      ACT_TICK: begin
        if (raise_q || silence_q) begin
          ticks_d = ticks_dec;
          if (ticks_dec == '0) begin
            alert_up_d      = raise_q;
            raise_d         = 1'b0;
            silence_d       = 1'b0;
            result_o.emit   = 1'b1;
            result_o.raised = raise_q;
          end
        end
      end
      ACT_DISARM: begin
        raise_d   = 1'b0;
        silence_d = 1'b0;
        ticks_d   = '0;
        if (alert_up_q) begin
          alert_up_d    = 1'b0;
          result_o.emit = 1'b1;
        end
      end
      default: begin
        // Unused action code: no change.
      end
    endcase
  end

  // State registers advance only when a word is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alert_up_q <= 1'b0;
      raise_q    <= 1'b0;
      silence_q  <= 1'b0;
      ticks_q    <= '0;
    end else if (step_i) begin
      alert_up_q <= alert_up_d;
      raise_q    <= raise_d;
      silence_q  <= silence_d;
      ticks_q    <= ticks_d;
    end
  end

  // At most one delay runs, and a running delay always has ticks left.
  `ADQ_ASSERT_NEVER(a_one_delay, clk_i, rst_ni, raise_q && silence_q)
  `ADQ_ASSERT(a_pending_count, clk_i, rst_ni, (raise_q || silence_q) |-> (ticks_q != '0))
  // A notification leaves the alert in the state it reports.
  `ADQ_ASSERT(a_emit_state, clk_i, rst_ni,
    (step_i && result_o.emit) |=> (alert_up_q == $past(result_o.raised)))

endmodule
`default_nettype wire

[sv/alert_delay_qualifier.sv]
// A word accepted into the input register is processed once the output register can take
// its result, and its notification is then offered on the result channel from that register.
// Throughput: one word per cycle; the single state update per word sets the pace.
// A pending notification stalls the input only while the result side holds ready low.
// Reset clears the alert state, delay counter, configuration registers and both channel valid flags.
// Top level of the alert delay qualifier: input register, configuration
// registers, output register. Depends on adq_pkg, the channel interfaces and adq_core.
`timescale 1ns / 1ps
`default_nettype none
module alert_delay_qualifier
  import adq_pkg::*;
#(
  parameter int unsigned DELAY_WIDTH = 32
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  adq_item_if.sink     item_i,
  adq_result_if.source result_o,
  adq_cfg_if.sink      cfg_i
);

  logic [ALERT_W-1:0]     alert_number_q;
  logic [DELAY_WIDTH-1:0] raise_delay_q;
  logic [DELAY_WIDTH-1:0] silence_delay_q;

  logic                   in_valid_q;
  item_t                  in_item_q;
  logic                   step;
  result_t                core_res;

  logic                   out_valid_q, out_valid_d;
  logic [ALERT_W-1:0]     out_alert_q;
  logic                   out_raised_q;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alert_number_q  <= '0;
      raise_delay_q   <= '0;
      silence_delay_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_ALERT_NUMBER:  alert_number_q  <= cfg_i.data[ALERT_W-1:0];
        CFG_RAISE_DELAY:   raise_delay_q   <= cfg_i.data[DELAY_WIDTH-1:0];
        CFG_SILENCE_DELAY: silence_delay_q <= cfg_i.data[DELAY_WIDTH-1:0];
        default: begin
          // Index beyond the register list: ignored.
        end
      endcase
    end
  end

  // The held word is processed once the output register can take its result.
  assign step         = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_item_q.action    <= item_i.action;
      in_item_q.condition <= item_i.condition;
    end
  end

  adq_core #(
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (in_item_q),
    .raise_delay_i  (raise_delay_q),
    .silence_delay_i(silence_delay_q),
    .result_o       (core_res)
  );

  // Output register: refilled on each processed word, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = core_res.emit;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && core_res.emit) begin
      out_alert_q  <= alert_number_q;
      out_raised_q <= core_res.raised;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.notified_alert = out_alert_q;
  assign result_o.raised         = out_raised_q;

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for alert_delay_qualifier: random and directed words,
// a scoreboard that predicts notifications, random idling and a long result stall.
// Depends on adq_pkg, the three channel interfaces and the alert_delay_qualifier RTL.
`timescale 1ns / 1ps
module tb;
  import adq_pkg::*;

  localparam int unsigned DELAY_W       = 32;
  localparam int unsigned IDLE_PCT      = 22;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned RANDOM_WORDS  = 900;
  localparam int unsigned PHASE_WORDS   = 80;
  localparam int unsigned REPORT_MAX    = 10;

  // Codes outside the defined sets; the block must ignore them.
  localparam logic [ACTION_W-1:0]  ACT_RESERVED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam logic [DELAY_W-1:0]   DELAY_MAX     = '1;

  logic clk_i;
  logic rst_ni;

  adq_item_if   item_bus ();
  adq_result_if note_bus ();
  adq_cfg_if    cfg_bus ();

  alert_delay_qualifier #(
    .DELAY_WIDTH(DELAY_W)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_bus),
    .result_o(note_bus),
    .cfg_i   (cfg_bus)
  );

  // Predicts raise and silence notifications and checks them in order.
  class alert_scoreboard;
    typedef struct packed {
      logic [ALERT_W-1:0] alert_num;
      logic               raised;
    } notice_t;

    notice_t            due_q[$];
    logic [ALERT_W-1:0] alert_num     = '0;
    logic [DELAY_W-1:0] raise_ticks   = '0;
    logic [DELAY_W-1:0] silence_ticks = '0;
    logic [DELAY_W-1:0] ticks_left    = '0;
    bit                 alert_up      = 1'b0;
    bit                 raise_run     = 1'b0;
    bit                 silence_run   = 1'b0;
    int unsigned        mismatches    = 0;

    function void fail_note(string what, logic [31:0] exp_val, logic [31:0] act_val);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, exp_val, act_val);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ALERT_NUMBER:  alert_num     = data[ALERT_W-1:0];
        CFG_RAISE_DELAY:   raise_ticks   = data[DELAY_W-1:0];
        CFG_SILENCE_DELAY: silence_ticks = data[DELAY_W-1:0];
        default: ;
      endcase
    endfunction

    function void post_notice(bit up);
      notice_t n;
      n.alert_num = alert_num;
      n.raised    = up;
      due_q.push_back(n);
    endfunction

    // Updates the alert state for one accepted word.
    function void note_item(logic [ACTION_W-1:0] act, logic cond);
      logic [DELAY_W-1:0] span;
      case (act)
        ACT_SAMPLE: begin
          if (cond == alert_up) begin
            // Agreeing sample cancels the delay toward the other state.
            if (alert_up) silence_run = 1'b0;
            else raise_run = 1'b0;
            if (!raise_run && !silence_run) ticks_left = '0;
          end else begin
            span = cond ? raise_ticks : silence_ticks;
            if (span == '0) begin
              raise_run   = 1'b0;
              silence_run = 1'b0;
              ticks_left  = '0;
              alert_up    = cond;
              post_notice(cond);
            end else if (cond && !raise_run) begin
              raise_run   = 1'b1;
              silence_run = 1'b0;
              ticks_left  = span;
            end else if (!cond && !silence_run) begin
              silence_run = 1'b1;
              raise_run   = 1'b0;
              ticks_left  = span;
            end
          end
        end
        ACT_TICK: begin
          if (raise_run || silence_run) begin
            ticks_left = ticks_left - 1'b1;
            if (ticks_left == '0) begin
              alert_up    = raise_run;
              raise_run   = 1'b0;
              silence_run = 1'b0;
              post_notice(alert_up);
            end
          end
        end
        ACT_DISARM: begin
          raise_run   = 1'b0;
          silence_run = 1'b0;
          ticks_left  = '0;
          if (alert_up) begin
            alert_up = 1'b0;
            post_notice(1'b0);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [ALERT_W-1:0] got_id, logic got_raised);
      notice_t n;
      if (due_q.size() == 0) begin
        fail_note("unexpected notification", '0, 32'({got_id, got_raised}));
      end else begin
        n = due_q.pop_front();
        if (got_id !== n.alert_num)
          fail_note("notified_alert", 32'(n.alert_num), 32'(got_id));
        if (got_raised !== n.raised)
          fail_note("raised", 32'(n.raised), 32'(got_raised));
      end
    endfunction

    function int unsigned outstanding();
      return due_q.size();
    endfunction

    function void flag_leftovers();
      while (due_q.size() != 0) begin
        fail_note("missing notification", 32'({due_q[0].alert_num, due_q[0].raised}), '0);
        void'(due_q.pop_front());
      end
    endfunction
  endclass

  alert_scoreboard board = new;

  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offers one word and waits until it is accepted.
  task automatic push_item(logic [ACTION_W-1:0] act, logic cond);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      item_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    item_bus.valid     = 1'b1;
    item_bus.action    = act;
    item_bus.condition = cond;
    do @(posedge clk_i); while (!item_bus.ready);
    board.note_item(act, cond);
  endtask

  // Drops valid and waits until every predicted notification has arrived.
  task automatic settle();
    @(negedge clk_i);
    item_bus.valid = 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic load_regs(logic [ALERT_W-1:0] id, logic [DELAY_W-1:0] up_span,
                           logic [DELAY_W-1:0] down_span);
    settle();
    write_reg(CFG_ALERT_NUMBER, CFG_DATA_W'(id));
    write_reg(CFG_RAISE_DELAY, CFG_DATA_W'(up_span));
    write_reg(CFG_SILENCE_DELAY, CFG_DATA_W'(down_span));
  endtask

  // Mostly short delays so that ticks expire; sometimes zero or very long.
  function automatic logic [DELAY_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return '0;
    if (r < 30) return DELAY_MAX;
    if (r < 38) return DELAY_W'($urandom);
    return DELAY_W'($urandom_range(6, 1));
  endfunction

  // Result side: random ready, with one long hold-off on request.
  initial begin
    note_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        note_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      note_bus.ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Checks every notification word that is accepted.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && note_bus.valid && note_bus.ready)
        board.check_result(note_bus.notified_alert, note_bus.raised);
    end
  end

  // Ends the run when no word moves on any channel for too long.
  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((item_bus.valid && item_bus.ready) || (note_bus.valid && note_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus: reset, directed words, then random phases.
  initial begin
    int unsigned counted;
    int unsigned phase;
    int unsigned k;
    int unsigned r;
    int unsigned flip_pct;
    logic        want;
    logic        cond;

    rst_ni             = 1'b0;
    item_bus.valid     = 1'b0;
    item_bus.action    = ACT_SAMPLE;
    item_bus.condition = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_ALERT_NUMBER;
    cfg_bus.data       = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: both delays zero, so every change is immediate.
    push_item(ACT_SAMPLE, 1'b1);
    push_item(ACT_SAMPLE, 1'b1);
    push_item(ACT_SAMPLE, 1'b0);
    push_item(ACT_TICK, 1'b1);
    push_item(ACT_RESERVED, 1'b1);
    push_item(ACT_SAMPLE, 1'b1);
    push_item(ACT_DISARM, 1'b0);
    push_item(ACT_DISARM, 1'b1);

    // Short delays: start, no restart, cancel, expiry; an unused index write.
    load_regs(8'hFF, 32'd3, 32'd2);
    write_reg(CFG_SPARE_IDX, '1);
    push_item(ACT_SAMPLE, 1'b1);
    push_item(ACT_TICK, 1'b0);
    push_item(ACT_SAMPLE, 1'b1);
    push_item(ACT_TICK, 1'b0);
    push_item(ACT_TICK, 1'b0);
    push_item(ACT_SAMPLE, 1'b0);
    push_item(ACT_SAMPLE, 1'b1);
    push_item(ACT_TICK, 1'b0);
    push_item(ACT_SAMPLE, 1'b0);
    push_item(ACT_TICK, 1'b1);
    push_item(ACT_TICK, 1'b1);
    push_item(ACT_SAMPLE, 1'b1);

    // A raise left running, then made immediate by a register rewrite.
    load_regs(8'h00, 32'd0, 32'd2);
    push_item(ACT_SAMPLE, 1'b1);

    // Longest delays; disarm silences the raised alert.
    load_regs(8'h5A, DELAY_MAX, DELAY_MAX);
    push_item(ACT_SAMPLE, 1'b0);
    push_item(ACT_TICK, 1'b0);
    push_item(ACT_DISARM, 1'b1);
    push_item(ACT_SAMPLE, 1'b1);
    push_item(ACT_TICK, 1'b0);

    // Random phases, each with its own register setting.
    counted = 0;
    phase   = 0;
    want    = 1'b0;
    while (counted < RANDOM_WORDS) begin
      r = $urandom_range(9);
      if (phase == 3) begin
        load_regs(8'($urandom), '0, '0);
        flip_pct = 85;
        hold_req = 1'b1;
      end else begin
        load_regs(r == 0 ? 8'h00 : (r == 1 ? 8'hFF : 8'($urandom)), pick_delay(),
                  pick_delay());
        flip_pct = 30;
      end
      no_idle = (phase == 1);
      k = 0;
      while (k < PHASE_WORDS && counted < RANDOM_WORDS) begin
        r    = $urandom_range(99);
        cond = 1'($urandom_range(1));
        if (r < 4) begin
          push_item(ACT_RESERVED, cond);
        end else begin
          if (r < 9) begin
            push_item(ACT_DISARM, cond);
          end else if (r < 45 || phase == 3) begin
            if ($urandom_range(99) < flip_pct) want = ~want;
            push_item(ACT_SAMPLE, want);
          end else begin
            push_item(ACT_TICK, cond);
          end
          counted++;
          k++;
        end
      end
      no_idle = 1'b0;
      phase++;
    end

    settle();
    board.flag_leftovers();
    if (board.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
